// ===== hdl/dhte_pkg.sv =====
// ----------------------------------------------------------------------------
// dhte_pkg
// Shared types and constants of the double hashing table engine.
// ----------------------------------------------------------------------------
package dhte_pkg;

  localparam int unsigned KEY_W     = 31;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned CODE_W    = 2;
  localparam int unsigned SLOT_W    = 5;
  localparam int unsigned DEF_SLOTS = 32;

  // key reduction works on this many key bits per cycle
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned N_DIGITS = (KEY_W + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned KEY_PAD  = N_DIGITS * DIGIT_W - KEY_W;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2
  } op_e;

  typedef enum logic [CODE_W-1:0] {
    RC_DONE = 2'd0,
    RC_FULL = 2'd1,
    RC_MISS = 2'd2
  } rc_e;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_OCC   = 2'd1,
    ST_DEL   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    rc_e               result_code;
    logic [SLOT_W-1:0] slot_index;
  } rsp_t;

  typedef struct packed {
    status_e          status;
    logic [KEY_W-1:0] value;
  } entry_t;

endpackage

// ===== hdl/dhte_hash.sv =====
// ----------------------------------------------------------------------------
// dhte_hash
// Multi-cycle remainder unit: key mod SLOTS and key mod (SLOTS-1), one digit
// of the key per cycle, most significant digit first.
// ----------------------------------------------------------------------------
module dhte_hash #(
  parameter int unsigned SLOTS = dhte_pkg::DEF_SLOTS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [dhte_pkg::KEY_W-1:0] key_i,
  output logic                       done_o,
  output logic [$clog2(SLOTS)-1:0]   rem_s_o,
  output logic [$clog2(SLOTS)-1:0]   rem_t_o
);
  import dhte_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CW    = IDX_W + DIGIT_W + 1;
  localparam int unsigned CNT_W = $clog2(N_DIGITS);
  localparam int unsigned KQ_W  = N_DIGITS * DIGIT_W;
  localparam logic [CW-1:0] MOD_S = CW'(SLOTS);
  localparam logic [CW-1:0] MOD_T = CW'(SLOTS - 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [KQ_W-1:0]     key_q, key_d;
  logic [IDX_W-1:0]    rs_q, rs_d;
  logic [IDX_W-1:0]    rt_q, rt_d;
  logic [DIGIT_W-1:0]  digit;
  logic [CW-1:0]       ts, tt;

  assign digit = key_q[KQ_W-1 -: DIGIT_W];

  // shift in one digit and reduce by compare and subtract
  always_comb begin
    ts = CW'({rs_q, digit});
    tt = CW'({rt_q, digit});
    for (int j = DIGIT_W - 1; j >= 0; j--) begin
      if (ts >= (MOD_S << j)) begin
        ts = ts - (MOD_S << j);
      end
      if (tt >= (MOD_T << j)) begin
        tt = tt - (MOD_T << j);
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    key_d  = key_q;
    rs_d   = rs_q;
    rt_d   = rt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      key_d  = {{KEY_PAD{1'b0}}, key_i};
      rs_d   = '0;
      rt_d   = '0;
    end else if (busy_q) begin
      rs_d  = IDX_W'(ts);
      rt_d  = IDX_W'(tt);
      key_d = key_q << DIGIT_W;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(N_DIGITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    rs_q  <= rs_d;
    rt_q  <= rt_d;
  end

  assign done_o  = done_q;
  assign rem_s_o = rs_q;
  assign rem_t_o = rt_q;

endmodule

// ===== hdl/dhte_mem.sv =====
// ----------------------------------------------------------------------------
// dhte_mem
// Slot table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dhte_mem #(
  parameter int unsigned SLOTS = dhte_pkg::DEF_SLOTS
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(SLOTS)-1:0] waddr_i,
  input  dhte_pkg::entry_t         wdata_i,
  input  logic [$clog2(SLOTS)-1:0] raddr_i,
  output dhte_pkg::entry_t         rdata_o
);
  import dhte_pkg::*;

  entry_t mem_q [SLOTS];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/dhte_ctrl.sv =====
// ----------------------------------------------------------------------------
// dhte_ctrl
// Operation sequencer: clearing pass, probe walk over the slot table with
// one read issued per cycle, write back on a free slot (insert) or a hit (delete) and the result register.
// ----------------------------------------------------------------------------
module dhte_ctrl #(
  parameter int unsigned SLOTS = dhte_pkg::DEF_SLOTS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  output logic                       req_stall_o,
  input  dhte_pkg::req_t             req_i,
  output logic                       rsp_valid_o,
  input  logic                       rsp_stall_i,
  output dhte_pkg::rsp_t             rsp_o,
  output logic                       hash_start_o,
  output logic [dhte_pkg::KEY_W-1:0] hash_key_o,
  input  logic                       hash_done_i,
  input  logic [$clog2(SLOTS)-1:0]   rem_s_i,
  input  logic [$clog2(SLOTS)-1:0]   rem_t_i,
  output logic                       mem_we_o,
  output logic [$clog2(SLOTS)-1:0]   mem_waddr_o,
  output dhte_pkg::entry_t           mem_wdata_o,
  output logic [$clog2(SLOTS)-1:0]   mem_raddr_o,
  input  dhte_pkg::entry_t           mem_rdata_i
);
  import dhte_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [IDX_W:0]   SUM_MOD  = (IDX_W + 1)'(SLOTS);

  state_e            state_q, state_d;
  logic [OP_W-1:0]   op_q, op_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [IDX_W-1:0]  pos_q, pos_d;
  logic [IDX_W-1:0]  step_q, step_d;
  logic [CNT_W-1:0]  issued_q, issued_d;
  logic [IDX_W-1:0]  chk_q, chk_d;
  logic              pend_q, pend_d;
  logic [IDX_W-1:0]  pend_pos_q, pend_pos_d;
  logic [IDX_W-1:0]  clr_q, clr_d;
  rc_e               code_q, code_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              rsp_valid_q, rsp_valid_d;
  rsp_t              rsp_q, rsp_d;
  logic [IDX_W:0]    pos_sum;
  logic [IDX_W-1:0]  next_pos;
  logic              issue;
  logic              done_probe;

  assign pos_sum  = {1'b0, pos_q} + {1'b0, step_q};
  assign next_pos = (pos_sum >= SUM_MOD) ? IDX_W'(pos_sum - SUM_MOD) : IDX_W'(pos_sum);
  assign issue    = (issued_q != CNT_W'(SLOTS));

  assign req_stall_o  = (state_q != S_IDLE);
  assign hash_key_o   = req_i.key;
  assign mem_raddr_o  = pos_q;
  assign rsp_valid_o  = rsp_valid_q;
  assign rsp_o        = rsp_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    pos_d       = pos_q;
    step_d      = step_q;
    issued_d    = issued_q;
    chk_d       = chk_q;
    pend_d      = pend_q;
    pend_pos_d  = pend_pos_q;
    clr_d       = clr_q;
    code_d      = code_q;
    idx_d       = idx_q;
    rsp_valid_d = rsp_valid_q;
    rsp_d       = rsp_q;
    hash_start_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = pend_pos_q;
    mem_wdata_o = '{status: ST_EMPTY, value: '0};
    done_probe  = 1'b0;

    if (rsp_valid_q && !rsp_stall_i) begin
      rsp_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        clr_d       = clr_q + 1'b1;
        if (clr_q == LAST_IDX) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          op_d  = req_i.opcode;
          key_d = req_i.key;
          if (req_i.opcode inside {OP_INSERT, OP_DELETE, OP_SEARCH}) begin
            hash_start_o = 1'b1;
            state_d      = S_HASH;
          end else begin
            code_d  = RC_MISS;
            idx_d   = '0;
            state_d = S_RESP;
          end
        end
      end
      S_HASH: begin
        if (hash_done_i) begin
          pos_d    = (rem_s_i == LAST_IDX) ? '0 : rem_s_i + 1'b1;
          step_d   = LAST_IDX - rem_t_i;
          issued_d = '0;
          chk_d    = '0;
          pend_d   = 1'b0;
          state_d  = S_PROBE;
        end
      end
      S_PROBE: begin
        pend_d = issue;
        if (issue) begin
          pend_pos_d = pos_q;
          pos_d      = next_pos;
          issued_d   = issued_q + 1'b1;
        end
        if (pend_q) begin
          chk_d = chk_q + 1'b1;
          if (op_q == OP_INSERT) begin
            if (mem_rdata_i.status != ST_OCC) begin
              mem_we_o    = 1'b1;
              mem_wdata_o = '{status: ST_OCC, value: key_q};
              code_d      = RC_DONE;
              idx_d       = pend_pos_q;
              done_probe  = 1'b1;
            end
          end else begin
            if (mem_rdata_i.status == ST_EMPTY) begin
              code_d     = RC_MISS;
              idx_d      = '0;
              done_probe = 1'b1;
            end else if (mem_rdata_i.status == ST_OCC && mem_rdata_i.value == key_q) begin
              if (op_q == OP_DELETE) begin
                mem_we_o    = 1'b1;
                mem_wdata_o = '{status: ST_DEL, value: '0};
              end
              code_d     = RC_DONE;
              idx_d      = pend_pos_q;
              done_probe = 1'b1;
            end
          end
          if (!done_probe && chk_q == LAST_IDX) begin
            code_d     = (op_q == OP_INSERT) ? RC_FULL : RC_MISS;
            idx_d      = '0;
            done_probe = 1'b1;
          end
          if (done_probe) begin
            pend_d  = 1'b0;
            state_d = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (!rsp_valid_q || !rsp_stall_i) begin
          rsp_valid_d = 1'b1;
          rsp_d       = '{result_code: code_q, slot_index: SLOT_W'(idx_q)};
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      issued_q    <= '0;
      chk_q       <= '0;
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      issued_q    <= issued_d;
      chk_q       <= chk_d;
      pend_q      <= pend_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    pos_q      <= pos_d;
    step_q     <= step_d;
    pend_pos_q <= pend_pos_d;
    code_q     <= code_d;
    idx_q      <= idx_d;
    rsp_q      <= rsp_d;
  end

`ifndef SYNTH
  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (state_q == S_CLEAR || state_q == S_PROBE))
    else $error("table write outside clearing pass or probe");

  a_hit_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we_o && state_q == S_PROBE) |=> (state_q == S_RESP))
    else $error("probe write did not end the walk");

  a_hash_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_done_i |-> (state_q == S_HASH))
    else $error("remainder unit finished outside hashing");

  a_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> (rsp_q.result_code == RC_DONE || rsp_q.slot_index == '0))
    else $error("slot index set on a failed operation");
`endif

endmodule

// ===== hdl/double_hash_table_engine_core.sv =====
// ----------------------------------------------------------------------------
// double_hash_table_engine_core
// Open-addressing hash table with double hashing: insert, delete, search.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over every slot of the slot
// table, with req_stall_o high, before it takes its first request. Each
// request is then accepted, passes through the remainder unit, which reduces
// the key four bits a cycle over N_DIGITS digits (8 for a 31-bit key) and
// hands over the remainders, walks the slot table one probe per cycle
// through its single read port with registered read data, and ends in the
// result register. The walk makes at most SLOTS probes and stops early when
// a slot settles the operation. An unused opcode goes straight to the result
// register with RC_MISS. One request is in flight at a time; a new one can
// be taken while the previous result waits in the result register.
module double_hash_table_engine_core #(
  parameter int unsigned SLOTS = dhte_pkg::DEF_SLOTS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_stall_o,
  input  dhte_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_stall_i,
  output dhte_pkg::rsp_t rsp_o
);
  import dhte_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOTS);

  logic              hash_start;
  logic [KEY_W-1:0]  hash_key;
  logic              hash_done;
  logic [IDX_W-1:0]  rem_s;
  logic [IDX_W-1:0]  rem_t;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;
  entry_t            mem_rdata;

  dhte_hash #(
    .SLOTS (SLOTS)
  ) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (hash_key),
    .done_o  (hash_done),
    .rem_s_o (rem_s),
    .rem_t_o (rem_t)
  );

  dhte_mem #(
    .SLOTS (SLOTS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  dhte_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_valid_i),
    .req_stall_o  (req_stall_o),
    .req_i        (req_i),
    .rsp_valid_o  (rsp_valid_o),
    .rsp_stall_i  (rsp_stall_i),
    .rsp_o        (rsp_o),
    .hash_start_o (hash_start),
    .hash_key_o   (hash_key),
    .hash_done_i  (hash_done),
    .rem_s_i      (rem_s),
    .rem_t_i      (rem_t),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

endmodule
